/* src/bpru_pkg.sv */
// shared types and constants for the pixel replication upscaler
// used by bpru_front, bpru_fifo and the top level; no dependencies
`default_nettype none

package bpru_pkg;

    localparam int PIX_W       = 24;
    localparam int SCALE_W     = 7;
    localparam int SWIDTH_W    = 13;
    localparam int SCALE_LIMIT = 100;
    localparam int PAD_W       = 2;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_LW    = 3;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWIDTH = 2'd1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_PULL = 1'b1;

    typedef struct packed {
        logic             group_end;
        logic [PAD_W-1:0] pad_bytes;
        logic             row_end;
    } t_flags;

    typedef struct packed {
        t_flags           flags;
        logic [PIX_W-1:0] pixel;
    } t_entry;

endpackage

`default_nettype wire

/* src/bpru_ram.sv */
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module bpru_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/bpru_front.sv */
// front part: accepts items, keeps the load/replay counters, owns the line store
// depends on bpru_pkg and bpru_ram; pushes read pixels with flags to the queue
`default_nettype none

module bpru_front #(
    parameter int MAX_WIDTH = 4096,
    parameter int AW        = 12,
    parameter int CW        = 13
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_action,
    input  wire logic [bpru_pkg::PIX_W-1:0]        i_pixel,
    input  wire logic [bpru_pkg::SCALE_W-1:0]      i_scale,
    input  wire logic [bpru_pkg::SWIDTH_W-1:0]     i_swidth,
    input  wire logic [bpru_pkg::Q_LW-1:0]         i_q_level,
    output logic                                   o_push,
    output bpru_pkg::t_entry                       o_entry
);

    logic                            r_emit, n_emit;
    logic [AW-1:0]                   r_load_col, n_load_col;
    logic [AW-1:0]                   r_read_col, n_read_col;
    logic [bpru_pkg::SCALE_W-1:0]    r_across, n_across;
    logic [bpru_pkg::SCALE_W-1:0]    r_down, n_down;
    logic                            r_rd_vld;
    bpru_pkg::t_flags                r_flags, n_flags;

    logic [bpru_pkg::SCALE_W-1:0]    scale_eff;
    logic [CW-1:0]                   swidth_ext, width_eff;
    logic [CW-1:0]                   ld_next, rd_next;
    logic [bpru_pkg::SCALE_W:0]      ac_next, dn_next, scale_ext;
    logic [3:0]                      pad_prod;
    logic [bpru_pkg::Q_LW-1:0]       used;
    logic                            accept, do_load, do_pull;
    logic [AW-1:0]                   ram_addr;
    logic [bpru_pkg::PIX_W-1:0]      ram_rdata;

    always_comb begin
        priority if (i_scale == '0) begin
            scale_eff = bpru_pkg::SCALE_W'(1);
        end else if (i_scale > bpru_pkg::SCALE_W'(bpru_pkg::SCALE_LIMIT)) begin
            scale_eff = bpru_pkg::SCALE_W'(bpru_pkg::SCALE_LIMIT);
        end else begin
            scale_eff = i_scale;
        end
    end

    assign swidth_ext = CW'(i_swidth);

    always_comb begin
        priority if (i_swidth == '0) begin
            width_eff = CW'(1);
        end else if (swidth_ext > CW'(MAX_WIDTH)) begin
            width_eff = CW'(MAX_WIDTH);
        end else begin
            width_eff = swidth_ext;
        end
    end

    assign used    = i_q_level + bpru_pkg::Q_LW'(r_rd_vld);
    assign o_ready = !r_emit || (used < bpru_pkg::Q_LW'(bpru_pkg::Q_DEPTH));
    assign accept  = i_valid && o_ready;
    assign do_load = accept && !r_emit && (i_action == bpru_pkg::ACT_LOAD);
    assign do_pull = accept && r_emit && (i_action == bpru_pkg::ACT_PULL);

    assign ld_next   = CW'(r_load_col) + CW'(1);
    assign rd_next   = CW'(r_read_col) + CW'(1);
    assign ac_next   = {1'b0, r_across} + 8'd1;
    assign dn_next   = {1'b0, r_down} + 8'd1;
    assign scale_ext = {1'b0, scale_eff};
    assign pad_prod  = {2'b00, width_eff[1:0]} * {2'b00, scale_eff[1:0]};

    always_comb begin
        n_emit     = r_emit;
        n_load_col = r_load_col;
        n_read_col = r_read_col;
        n_across   = r_across;
        n_down     = r_down;
        n_flags    = '0;
        if (do_load) begin
            if (ld_next >= width_eff) begin
                n_load_col = '0;
                n_read_col = '0;
                n_across   = '0;
                n_down     = '0;
                n_emit     = 1'b1;
            end else begin
                n_load_col = ld_next[AW-1:0];
            end
        end else if (do_pull) begin
            if (ac_next >= scale_ext) begin
                n_across = '0;
                if (rd_next >= width_eff) begin
                    n_read_col        = '0;
                    n_flags.row_end   = 1'b1;
                    n_flags.pad_bytes = pad_prod[1:0];
                    if (dn_next >= scale_ext) begin
                        n_down            = '0;
                        n_flags.group_end = 1'b1;
                        n_emit            = 1'b0;
                        n_load_col        = '0;
                    end else begin
                        n_down = dn_next[bpru_pkg::SCALE_W-1:0];
                    end
                end else begin
                    n_read_col = rd_next[AW-1:0];
                end
            end else begin
                n_across = ac_next[bpru_pkg::SCALE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit     <= 1'b0;
            r_load_col <= '0;
            r_read_col <= '0;
            r_across   <= '0;
            r_down     <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            r_emit     <= n_emit;
            r_load_col <= n_load_col;
            r_read_col <= n_read_col;
            r_across   <= n_across;
            r_down     <= n_down;
            r_rd_vld   <= do_pull;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags <= n_flags;
    end

    assign ram_addr = r_emit ? r_read_col : r_load_col;

    bpru_ram #(
        .WIDTH (bpru_pkg::PIX_W),
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_addr  (ram_addr),
        .i_wdata (i_pixel),
        .o_rdata (ram_rdata)
    );

    assign o_push        = r_rd_vld;
    assign o_entry.pixel = ram_rdata;
    assign o_entry.flags = r_flags;

endmodule

`default_nettype wire

/* src/bpru_fifo.sv */
// back part: short result queue whose head drives the output stream
// depends on bpru_pkg
`default_nettype none

module bpru_fifo (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    input  wire bpru_pkg::t_entry          i_entry,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output bpru_pkg::t_entry               o_entry,
    output logic [bpru_pkg::Q_LW-1:0]      o_level
);

    bpru_pkg::t_entry                r_mem [bpru_pkg::Q_DEPTH];
    logic [bpru_pkg::Q_AW-1:0]       r_wr_ptr, r_rd_ptr;
    logic [bpru_pkg::Q_LW-1:0]       r_count, n_count;
    logic                            pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_entry = r_mem[r_rd_ptr];
    assign o_level = r_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + bpru_pkg::Q_LW'(1);
        end else if (!i_push && pop) begin
            n_count = r_count - bpru_pkg::Q_LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + bpru_pkg::Q_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + bpru_pkg::Q_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

/* src/bmp_pixel_replication_upscaler_core.sv */
// pixel replication upscaler top: config registers, front part and result queue
// depends on bpru_pkg, bpru_front, bpru_ram, bpru_fifo
// throughput: one item per cycle, loads and pulls alike, with the sink ready
// pull path: a pull's pixel is read from the line store into a register, then
// pushed into a four-entry queue whose head drives m_axis; loads give no result
// reset: synchronous active low, counters cleared, scale and width set to 1,
// line store left as is (no clearing pass)
`default_nettype none

module bmp_pixel_replication_upscaler_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [23:0]                          s_axis_tdata,  // blue, green, red
    input  wire logic                                 s_axis_tuser,  // action
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [23:0]                               m_axis_tdata,  // out_blue, out_green, out_red
    output logic                                      m_axis_tlast,
    output logic [2:0]                                m_axis_tuser,  // group_end, pad_bytes
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [bpru_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [bpru_pkg::SWIDTH_W-1:0]        i_cfg_data
);

    localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CWR  = $clog2(MAX_WIDTH + 1);
    localparam int CW   = (CWR > bpru_pkg::SWIDTH_W) ? CWR : bpru_pkg::SWIDTH_W;

    logic [bpru_pkg::SCALE_W-1:0]   r_scale;
    logic [bpru_pkg::SWIDTH_W-1:0]  r_swidth;
    logic                           cfg_we;
    logic                           q_push;
    bpru_pkg::t_entry               q_in, q_out;
    logic [bpru_pkg::Q_LW-1:0]      q_level;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= bpru_pkg::SCALE_W'(1);
            r_swidth <= bpru_pkg::SWIDTH_W'(1);
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                bpru_pkg::CFG_SCALE:  r_scale  <= i_cfg_data[bpru_pkg::SCALE_W-1:0];
                bpru_pkg::CFG_SWIDTH: r_swidth <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bpru_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW),
        .CW        (CW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_action  (s_axis_tuser),
        .i_pixel   (s_axis_tdata),
        .i_scale   (r_scale),
        .i_swidth  (r_swidth),
        .i_q_level (q_level),
        .o_push    (q_push),
        .o_entry   (q_in)
    );

    bpru_fifo u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_entry (q_out),
        .o_level (q_level)
    );

    assign m_axis_tdata = q_out.pixel;
    assign m_axis_tlast = q_out.flags.row_end;
    assign m_axis_tuser = {q_out.flags.group_end, q_out.flags.pad_bytes};

    // queue never overruns
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_level < bpru_pkg::Q_LW'(bpru_pkg::Q_DEPTH)) || m_axis_tready)
        else $error("result queue overrun");

    // group end only on a row end
    a_group_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tlast)
        else $error("group end without row end");

    // padding only at row end
    a_pad_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[1:0] == 2'b00)
        else $error("pad bytes inside a row");

    // a full queue with a stalled sink blocks pulls
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_level == bpru_pkg::Q_LW'(bpru_pkg::Q_DEPTH) |-> !q_push || m_axis_tready)
        else $error("push into full queue");

endmodule

`default_nettype wire
